// ===== hw/rtl/nlr_pkg.sv =====
// ----------------------------------------------------------------------------
// nlr_pkg: shared types of the numeric literal recognizer
// Parser phase encoding used by the step logic and the top level.
// ----------------------------------------------------------------------------
package nlr_pkg;

  typedef enum logic [17:0] {
    PH_START  = 18'b000000000000000001,
    PH_SIGNED = 18'b000000000000000010,
    PH_I      = 18'b000000000000000100,
    PH_IN     = 18'b000000000000001000,
    PH_INF    = 18'b000000000000010000,
    PH_N      = 18'b000000000000100000,
    PH_NA     = 18'b000000000001000000,
    PH_NAN    = 18'b000000000010000000,
    PH_POPEN  = 18'b000000000100000000,
    PH_PDIG   = 18'b000000001000000000,
    PH_INT    = 18'b000000010000000000,
    PH_DOT    = 18'b000000100000000000,
    PH_FRAC   = 18'b000001000000000000,
    PH_EMARK  = 18'b000010000000000000,
    PH_ESIGN  = 18'b000100000000000000,
    PH_EDIG   = 18'b001000000000000000,
    PH_TRAIL  = 18'b010000000000000000,
    PH_REJECT = 18'b100000000000000000
  } phase_t;

  localparam int unsigned CharWidth = 8;

endpackage

// ===== hw/rtl/numeric_literal_recognizer.sv =====
// A terminator beat is accepted into the input register and moves on into the
// result register once that has room, which raises out_valid.
// Throughput: one character beat per cycle; the phase register updates once
// per beat through a single level of step logic. Only a terminator held
// behind a stalled verdict stalls the input.
// Reset: synchronous rst empties both registers and sets the phase to start.
// ----------------------------------------------------------------------------
// numeric_literal_recognizer: streaming number syntax checker
// Parses one character per beat and reports on each terminator beat whether
// the text since the previous terminator reads as a number.
// ----------------------------------------------------------------------------
module numeric_literal_recognizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_number
);

  logic            s1_valid;
  logic [7:0]      s1_ch;
  logic            s1_eot;
  logic            s1_fire;
  logic            out_free;
  logic            in_fire;
  nlr_pkg::phase_t phase;
  nlr_pkg::phase_t phase_next;
  logic            accepting;

  // A character beat never waits; a terminator waits for room in the
  // result register.
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && (!s1_eot || out_free);
  assign in_stall = s1_valid && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  nlr_step u_step (
    .phase      (phase),
    .ch         (s1_ch),
    .phase_next (phase_next),
    .accepting  (accepting)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch  <= ch;
      s1_eot <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nlr_pkg::PH_START;
    end else if (s1_fire) begin
      phase <= s1_eot ? nlr_pkg::PH_START : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_eot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_eot) begin
      is_number <= accepting;
    end
  end

`ifndef SYNTHESIS
  a_eot_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_eot |=> phase == nlr_pkg::PH_START)
    else $error("phase did not return to start after a terminator");

  a_out_from_eot: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_eot))
    else $error("result appeared without a terminator beat");

  a_reject_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == nlr_pkg::PH_REJECT && s1_fire && !s1_eot |=> phase == nlr_pkg::PH_REJECT)
    else $error("rejecting phase left before the terminator");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_eot && out_valid && out_stall)
    else $error("input stalled without a blocked terminator");
`endif

endmodule

// ===== hw/rtl/nlr_step.sv =====
// ----------------------------------------------------------------------------
// nlr_step: one character step of the recognizer
// Classifies a byte and computes the next parser phase, plus whether the
// current phase ends a valid number.
// ----------------------------------------------------------------------------
module nlr_step (
  input  nlr_pkg::phase_t              phase,
  input  logic [nlr_pkg::CharWidth-1:0] ch,
  output nlr_pkg::phase_t              phase_next,
  output logic                         accepting
);

  typedef struct packed {
    logic blank;
    logic digit;
    logic sign;
    logic dot;
    logic lparen;
    logic rparen;
    logic let_i;
    logic let_n;
    logic let_f;
    logic let_a;
    logic let_e;
  } char_class_t;

  logic [nlr_pkg::CharWidth-1:0] folded;
  char_class_t                   cls;
  nlr_pkg::phase_t               body;

  // Upper-case ASCII letters fold onto lower case; other bytes pass.
  assign folded = (ch >= 8'h41 && ch <= 8'h5A) ? (ch | 8'h20) : ch;

  always_comb begin
    cls.blank  = (ch == 8'h20) || (ch == 8'h09);
    cls.digit  = (ch >= 8'h30) && (ch <= 8'h39);
    cls.sign   = (ch == 8'h2B) || (ch == 8'h2D);
    cls.dot    = (ch == 8'h2E);
    cls.lparen = (ch == 8'h28);
    cls.rparen = (ch == 8'h29);
    cls.let_i  = (folded == 8'h69);
    cls.let_n  = (folded == 8'h6E);
    cls.let_f  = (folded == 8'h66);
    cls.let_a  = (folded == 8'h61);
    cls.let_e  = (folded == 8'h65);
  end

  // First significant character after the optional sign.
  always_comb begin
    priority if (cls.let_i) begin
      body = nlr_pkg::PH_I;
    end else if (cls.let_n) begin
      body = nlr_pkg::PH_N;
    end else if (cls.digit) begin
      body = nlr_pkg::PH_INT;
    end else if (cls.dot) begin
      body = nlr_pkg::PH_DOT;
    end else begin
      body = nlr_pkg::PH_REJECT;
    end
  end

  always_comb begin
    phase_next = nlr_pkg::PH_REJECT;
    unique case (phase)
      nlr_pkg::PH_START: begin
        if (cls.blank)     phase_next = nlr_pkg::PH_START;
        else if (cls.sign) phase_next = nlr_pkg::PH_SIGNED;
        else               phase_next = body;
      end
      nlr_pkg::PH_SIGNED: phase_next = body;
      nlr_pkg::PH_I:  if (cls.let_n) phase_next = nlr_pkg::PH_IN;
      nlr_pkg::PH_IN: if (cls.let_f) phase_next = nlr_pkg::PH_INF;
      nlr_pkg::PH_N:  if (cls.let_a) phase_next = nlr_pkg::PH_NA;
      nlr_pkg::PH_NA: if (cls.let_n) phase_next = nlr_pkg::PH_NAN;
      nlr_pkg::PH_INF: if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      nlr_pkg::PH_NAN: begin
        if (cls.lparen)     phase_next = nlr_pkg::PH_POPEN;
        else if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      end
      nlr_pkg::PH_POPEN: if (cls.digit) phase_next = nlr_pkg::PH_PDIG;
      nlr_pkg::PH_PDIG: begin
        if (cls.digit)       phase_next = nlr_pkg::PH_PDIG;
        else if (cls.rparen) phase_next = nlr_pkg::PH_TRAIL;
      end
      nlr_pkg::PH_INT: begin
        if (cls.digit)      phase_next = nlr_pkg::PH_INT;
        else if (cls.dot)   phase_next = nlr_pkg::PH_FRAC;
        else if (cls.let_e) phase_next = nlr_pkg::PH_EMARK;
        else if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      end
      nlr_pkg::PH_DOT: if (cls.digit) phase_next = nlr_pkg::PH_FRAC;
      nlr_pkg::PH_FRAC: begin
        if (cls.digit)      phase_next = nlr_pkg::PH_FRAC;
        else if (cls.let_e) phase_next = nlr_pkg::PH_EMARK;
        else if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      end
      nlr_pkg::PH_EMARK: begin
        if (cls.sign)       phase_next = nlr_pkg::PH_ESIGN;
        else if (cls.digit) phase_next = nlr_pkg::PH_EDIG;
      end
      nlr_pkg::PH_ESIGN: if (cls.digit) phase_next = nlr_pkg::PH_EDIG;
      nlr_pkg::PH_EDIG: begin
        if (cls.digit)      phase_next = nlr_pkg::PH_EDIG;
        else if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      end
      nlr_pkg::PH_TRAIL: if (cls.blank) phase_next = nlr_pkg::PH_TRAIL;
      default: phase_next = nlr_pkg::PH_REJECT;
    endcase
  end

  assign accepting = (phase == nlr_pkg::PH_INF)  || (phase == nlr_pkg::PH_NAN)  ||
                     (phase == nlr_pkg::PH_INT)  || (phase == nlr_pkg::PH_FRAC) ||
                     (phase == nlr_pkg::PH_EDIG) || (phase == nlr_pkg::PH_TRAIL);

endmodule

// ===== tb/sv/nlr_checker.sv =====
// ----------------------------------------------------------------------------
// nlr_checker: scoreboard for the numeric literal recognizer
// Watches both channels, tracks the parser phase of every accepted character
// beat and compares each verdict with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module nlr_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       ch,
  input  logic             end_of_text,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             is_number,
  output int unsigned      mismatch_count,
  output int unsigned      verdicts_pending,
  output int unsigned      verdicts_checked,
  output int unsigned      numbers_seen
);

  nlr_pkg::phase_t text_phase;
  logic            expected_verdicts[$];
  logic            want;

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c == "+" || c == "-";
  endfunction

  // First significant character once blanks and sign are behind us.
  function automatic nlr_pkg::phase_t body_phase(logic [7:0] c, logic [7:0] f);
    if (f == "i") return nlr_pkg::PH_I;
    if (f == "n") return nlr_pkg::PH_N;
    if (is_digit(c)) return nlr_pkg::PH_INT;
    if (c == ".") return nlr_pkg::PH_DOT;
    return nlr_pkg::PH_REJECT;
  endfunction

  function automatic nlr_pkg::phase_t step_phase(nlr_pkg::phase_t ph, logic [7:0] c);
    logic [7:0] f;
    f = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    case (ph)
      nlr_pkg::PH_START: begin
        if (is_blank(c)) return nlr_pkg::PH_START;
        if (is_sign(c)) return nlr_pkg::PH_SIGNED;
        return body_phase(c, f);
      end
      nlr_pkg::PH_SIGNED: return body_phase(c, f);
      nlr_pkg::PH_I:      return (f == "n") ? nlr_pkg::PH_IN : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_IN:     return (f == "f") ? nlr_pkg::PH_INF : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_N:      return (f == "a") ? nlr_pkg::PH_NA : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_NA:     return (f == "n") ? nlr_pkg::PH_NAN : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_INF:    return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_NAN: begin
        if (c == "(") return nlr_pkg::PH_POPEN;
        return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_POPEN:  return is_digit(c) ? nlr_pkg::PH_PDIG : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_PDIG: begin
        if (is_digit(c)) return nlr_pkg::PH_PDIG;
        return (c == ")") ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_INT: begin
        if (is_digit(c)) return nlr_pkg::PH_INT;
        if (c == ".") return nlr_pkg::PH_FRAC;
        if (f == "e") return nlr_pkg::PH_EMARK;
        return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_DOT:    return is_digit(c) ? nlr_pkg::PH_FRAC : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_FRAC: begin
        if (is_digit(c)) return nlr_pkg::PH_FRAC;
        if (f == "e") return nlr_pkg::PH_EMARK;
        return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_EMARK: begin
        if (is_sign(c)) return nlr_pkg::PH_ESIGN;
        return is_digit(c) ? nlr_pkg::PH_EDIG : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_ESIGN:  return is_digit(c) ? nlr_pkg::PH_EDIG : nlr_pkg::PH_REJECT;
      nlr_pkg::PH_EDIG: begin
        if (is_digit(c)) return nlr_pkg::PH_EDIG;
        return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      end
      nlr_pkg::PH_TRAIL:  return is_blank(c) ? nlr_pkg::PH_TRAIL : nlr_pkg::PH_REJECT;
      default:            return nlr_pkg::PH_REJECT;
    endcase
  endfunction

  function automatic logic ends_as_number(nlr_pkg::phase_t ph);
    case (ph)
      nlr_pkg::PH_INF, nlr_pkg::PH_NAN, nlr_pkg::PH_INT,
      nlr_pkg::PH_FRAC, nlr_pkg::PH_EDIG, nlr_pkg::PH_TRAIL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  initial begin
    mismatch_count   = 0;
    verdicts_pending = 0;
    verdicts_checked = 0;
    numbers_seen     = 0;
    text_phase       = nlr_pkg::PH_START;
  end

  always @(posedge clk) begin
    if (rst) begin
      text_phase = nlr_pkg::PH_START;
      expected_verdicts.delete();
      verdicts_pending = 0;
    end else begin
      // The verdict of a terminator cannot leave in the cycle it enters, so
      // the output side is settled before this cycle's input beat.
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("verdict is_number=%0d arrived with none outstanding", is_number);
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          if (is_number) numbers_seen++;
          if (is_number !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("verdict %0d: expected is_number=%0d, got %0d",
                       verdicts_checked, want, is_number);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (end_of_text) begin
          expected_verdicts.push_back(ends_as_number(text_phase));
          text_phase = nlr_pkg::PH_START;
        end else begin
          text_phase = step_phase(text_phase, ch);
        end
      end
      verdicts_pending = expected_verdicts.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the numeric literal recognizer
// Streams directed and random texts one character beat at a time with random
// gaps and output stalls; the checker scores every verdict.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic [7:0] text_t[$];

  localparam int unsigned WatchdogLimit = 200;
  localparam int unsigned RandomBeats   = 650;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic [7:0] ch          = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_stall   = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       is_number;

  int unsigned mismatch_count;
  int unsigned verdicts_pending;
  int unsigned verdicts_checked;
  int unsigned numbers_seen;
  int unsigned texts_sent  = 0;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          calm        = 1'b0;

  numeric_literal_recognizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ch          (ch),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_number   (is_number)
  );

  nlr_checker u_chk (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .ch               (ch),
    .end_of_text      (end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .is_number        (is_number),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending),
    .verdicts_checked (verdicts_checked),
    .numbers_seen     (numbers_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: holds off a random number of cycles before taking each verdict.
  initial begin : result_sink
    int unsigned gap;
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic eot);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    ch          = c;
    end_of_text = eot;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // The terminator carries a random byte, which the block must ignore.
  task automatic send_text(input text_t t);
    foreach (t[i]) send_beat(t[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    texts_sent++;
  endtask

  task automatic send_str(input string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    in_valid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    text_t       t;
    string       word;
    int unsigned n;
    int unsigned pos;
    bit          paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed texts: empty and blank, lone signs, the special words,
    // broken payloads and exponents, and bytes outside printable ASCII.
    send_str("");
    send_str(" \t ");
    send_str("+");
    send_str("- ");
    send_str("0");
    send_str("9");
    send_str("inf");
    send_str("-INF ");
    send_str("\t+iNf\t");
    send_str("infinity");
    send_str("nan");
    send_str("NaN(0123456789)");
    send_str("nan()");
    send_str("nan(12");
    send_str("nanx");
    send_str("1e");
    send_str("1E+");
    send_str("1.5e-10");
    send_str("-.5E9 ");
    send_str(".");
    send_str("5.");
    send_str("1 2");
    t = '{8'h31, 8'h00};
    send_text(t);
    t = '{8'h80, 8'h37};
    send_text(t);
    t = '{8'hFF};
    send_text(t);

    // Random texts: mostly well-formed with random content, some corrupted,
    // some pure noise.
    while (beats_sent < RandomBeats) begin
      if (texts_sent % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!paused && beats_sent >= RandomBeats / 2) begin
        drain_verdicts();
        paused = 1'b1;
      end
      t.delete();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, 6);
        repeat (n) t.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) t.push_back($urandom_range(0, 1) ? " " : 8'h09);
        if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? "+" : "-");
        case ($urandom_range(0, 5))
          0, 1: begin
            word = $urandom_range(0, 1) ? "inf" : "nan";
            for (int i = 0; i < 3; i++)
              t.push_back(word[i] & ($urandom_range(0, 1) ? 8'hDF : 8'hFF));
            if (word == "nan" && $urandom_range(0, 1)) begin
              t.push_back("(");
              repeat ($urandom_range(0, 3)) t.push_back("0" + 8'($urandom_range(0, 9)));
              if ($urandom_range(0, 7) != 0) t.push_back(")");
            end
          end
          default: begin
            repeat ($urandom_range(0, 4)) t.push_back("0" + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 1)) begin
              t.push_back(".");
              repeat ($urandom_range(0, 4)) t.push_back("0" + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 4) < 2) begin
              t.push_back($urandom_range(0, 1) ? "e" : "E");
              if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? "+" : "-");
              repeat ($urandom_range(0, 3)) t.push_back("0" + 8'($urandom_range(0, 9)));
            end
          end
        endcase
        repeat ($urandom_range(0, 3)) t.push_back($urandom_range(0, 1) ? " " : 8'h09);
        if (t.size() > 0 && $urandom_range(0, 3) == 0) begin
          pos = $urandom_range(0, t.size() - 1);
          case ($urandom_range(0, 2))
            0: t[pos] = 8'($urandom_range(0, 255));
            1: t.insert(pos, 8'($urandom_range(0, 255)));
            default: void'(t.pop_back());
          endcase
        end
      end
      send_text(t);
    end

    drain_verdicts();
    repeat (4) @(negedge clk);
    $display("Checked %0d verdicts (%0d numbers) from %0d texts in %0d character beats.",
             verdicts_checked, numbers_seen, texts_sent, beats_sent);
    $display("Texts mixed blanks, signs, INF, NAN payloads, numerals and noise bytes.");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d verdict mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
